// ===== design/adll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types and constants for the array based doubly linked list.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int MAX_RESULTS    = 16;

  // fixed field widths of the beats
  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int ENTRY_W  = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_AFTER = 3'd1,
    OP_ADD_TAIL  = 3'd2,
    OP_DEL_HEAD  = 3'd3,
    OP_DEL_AFTER = 3'd4,
    OP_DEL_TAIL  = 3'd5,
    OP_READ_OUT  = 3'd6,
    OP_CLEAR     = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_FETCH2,
    S_LINK,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== design/array_doubly_linked_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list kept in a fixed slot store, one operation per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one list operation (add at head, add after a slot,
// add at tail, delete head, delete after a slot, delete tail, read out, clear).
// A new entry always lands in the lowest numbered free slot. Refused work
// (full list, empty list, unlinked position) leaves the store untouched and
// returns a status. Every operation gives one result beat, except read out,
// which gives one beat per entry from head to tail (at most MAX_RESULTS) with
// out_last on the final one. The block takes one operation at a time: in_stall
// is high from acceptance until the final result has been loaded into the
// output register. Clear, refusals decided up front and changes to an empty or
// single-entry list pass decide and emit; add head/tail decide, link, emit;
// the head/tail deletes and delete after on the tail decide, fetch, emit; add
// after decide, fetch, link, emit; delete after decide, fetch, fetch2, emit;
// read out decide, fetch, emit, then fetch, emit for each further entry. The
// steps come from the one shared read address and the one write port per link
// array: a link read is registered before use and a second write to one link
// array needs a further step. A stalled output beat holds the sequencer in its
// emit step. There is no clearing pass: free marks are flip-flops and links are
// only ever read from linked slots, which were written when they were taken.
// ----------------------------------------------------------------------------
module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // operation beats
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [ENTRY_W-1:0]  in_entry_data,
  // result beats
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [ENTRY_W-1:0]       out_entry_data_out,
  output logic                     out_last,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LINK_W = $clog2(DEPTH + 1);   // one extra code for the null link
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LIM_W  = $clog2(MAX_RESULTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);

  // link and data stores
  logic [LINK_W-1:0]     next_mem [DEPTH];
  logic [LINK_W-1:0]     prev_mem [DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DEPTH];

  // sequencer and list state
  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [IDX_W-1:0]      new_r;
  logic [LINK_W-1:0]     aux_r, aux_nxt;
  logic [LIM_W-1:0]      k_r, k_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DEPTH-1:0]      free_r, free_nxt;

  // pending result
  status_t               res_status_r, res_status_nxt;
  logic [IDX_W-1:0]      res_slot_r, res_slot_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                  res_last_r, res_last_nxt;

  // registered store reads
  logic [LINK_W-1:0]     next_rd_r;
  logic [LINK_W-1:0]     prev_rd_r;
  logic [DATA_WIDTH-1:0] data_rd_r;

  // output register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [ENTRY_W-1:0]    out_data_r;
  logic                  out_last_r;
  logic [COUNT_W-1:0]    out_count_r;

  // store ports
  logic                  nx_we, pv_we, dat_we, rd_en;
  logic [IDX_W-1:0]      nx_wa, pv_wa, rd_addr;
  logic [LINK_W-1:0]     nx_wd, pv_wd;

  logic [IDX_W-1:0]      lowest_free;
  logic [IDX_W-1:0]      pos_idx;
  logic                  pos_ok;
  logic                  full;
  logic                  lim_hit;
  logic                  emit_go;
  logic                  accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pos_idx  = IDX_W'(pos_r);
  assign pos_ok   = (32'(pos_r) < DEPTH) && !free_r[pos_idx];
  assign full     = (32'(count_r) >= DEPTH);
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  // final beat of a read out once count or MAX_RESULTS entries, whichever is smaller, have gone
  assign lim_hit  = (32'(k_r) + 32'd1) ==
                    ((32'(count_r) < MAX_RESULTS) ? 32'(count_r) : MAX_RESULTS);

  // lowest free slot, priority over the free marks
  always_comb begin
    lowest_free = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_r[i]) lowest_free = IDX_W'(i);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: decide, fetch links, write links, emit
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    aux_nxt        = aux_r;
    k_nxt          = k_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_data_nxt   = res_data_r;
    res_last_nxt   = res_last_r;
    nx_we   = 1'b0;
    nx_wa   = '0;
    nx_wd   = NULL_LINK;
    pv_we   = 1'b0;
    pv_wa   = '0;
    pv_wd   = NULL_LINK;
    dat_we  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        // default result: ok, single beat, no data
        res_status_nxt = ST_OK;
        res_slot_nxt   = '0;
        res_data_nxt   = '0;
        res_last_nxt   = 1'b1;
        state_nxt      = S_EMIT;
        case (op_r)
          OP_ADD_HEAD, OP_ADD_TAIL: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              free_nxt[new_r] = 1'b0;
              count_nxt       = count_r + 1'b1;
              dat_we          = 1'b1;
              res_slot_nxt    = new_r;
              nx_we = 1'b1;
              nx_wa = new_r;
              pv_we = 1'b1;
              pv_wa = new_r;
              if (count_r == '0) begin
                head_nxt = new_r;
                tail_nxt = new_r;
              end else if (op_r == OP_ADD_HEAD) begin
                nx_wd     = LINK_W'(head_r);
                aux_nxt   = LINK_W'(head_r);
                head_nxt  = new_r;
                state_nxt = S_LINK;
              end else begin
                pv_wd     = LINK_W'(tail_r);
                aux_nxt   = LINK_W'(tail_r);
                tail_nxt  = new_r;
                state_nxt = S_LINK;
              end
            end
          end
          OP_ADD_AFTER: begin
            if (!pos_ok) begin
              res_status_nxt = ST_BAD_POS;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = pos_idx;
              state_nxt = S_FETCH;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else if (count_r == CNT_W'(1)) begin
              free_nxt[head_r] = 1'b1;
              count_nxt        = '0;
              res_slot_nxt     = head_r;
              head_nxt         = '0;
              tail_nxt         = '0;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = (op_r == OP_DEL_HEAD) ? head_r : tail_r;
              state_nxt = S_FETCH;
            end
          end
          OP_DEL_AFTER: begin
            if (!pos_ok) begin
              res_status_nxt = ST_BAD_POS;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = pos_idx;
              state_nxt = S_FETCH;
            end
          end
          OP_READ_OUT: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              aux_nxt   = LINK_W'(head_r);
              k_nxt     = '0;
              state_nxt = S_FETCH;
            end
          end
          default: begin
            // clear: free everything, data words kept
            free_nxt  = '1;
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
          end
        endcase
      end

      S_FETCH: begin
        state_nxt = S_EMIT;
        case (op_r)
          OP_ADD_AFTER: begin
            free_nxt[new_r] = 1'b0;
            count_nxt       = count_r + 1'b1;
            dat_we          = 1'b1;
            res_slot_nxt    = new_r;
            nx_we = 1'b1;
            nx_wa = new_r;
            nx_wd = next_rd_r;
            pv_we = 1'b1;
            pv_wa = new_r;
            pv_wd = LINK_W'(pos_idx);
            aux_nxt   = next_rd_r;
            state_nxt = S_LINK;
          end
          OP_DEL_HEAD: begin
            head_nxt         = next_rd_r[IDX_W-1:0];
            pv_we            = 1'b1;
            pv_wa            = next_rd_r[IDX_W-1:0];
            free_nxt[head_r] = 1'b1;
            count_nxt        = count_r - 1'b1;
            res_slot_nxt     = head_r;
          end
          OP_DEL_TAIL: begin
            tail_nxt         = prev_rd_r[IDX_W-1:0];
            nx_we            = 1'b1;
            nx_wa            = prev_rd_r[IDX_W-1:0];
            free_nxt[tail_r] = 1'b1;
            count_nxt        = count_r - 1'b1;
            res_slot_nxt     = tail_r;
          end
          OP_DEL_AFTER: begin
            if (next_rd_r >= NULL_LINK) begin
              // position is the tail: nothing after it
              res_status_nxt = ST_EMPTY;
            end else begin
              aux_nxt   = next_rd_r;
              rd_en     = 1'b1;
              rd_addr   = next_rd_r[IDX_W-1:0];
              state_nxt = S_FETCH2;
            end
          end
          OP_READ_OUT: begin
            res_status_nxt = ST_OK;
            res_slot_nxt   = aux_r[IDX_W-1:0];
            res_data_nxt   = data_rd_r;
            res_last_nxt   = lim_hit || (next_rd_r >= NULL_LINK);
            aux_nxt        = next_rd_r;
            k_nxt          = k_r + 1'b1;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FETCH2: begin
        // delete after: unlink aux, its successor is in next_rd_r
        nx_we = 1'b1;
        nx_wa = pos_idx;
        nx_wd = next_rd_r;
        if (next_rd_r >= NULL_LINK) begin
          tail_nxt = pos_idx;
        end else begin
          pv_we = 1'b1;
          pv_wa = next_rd_r[IDX_W-1:0];
          pv_wd = LINK_W'(pos_idx);
        end
        free_nxt[aux_r[IDX_W-1:0]] = 1'b1;
        count_nxt    = count_r - 1'b1;
        res_slot_nxt = aux_r[IDX_W-1:0];
        state_nxt    = S_EMIT;
      end

      S_LINK: begin
        state_nxt = S_EMIT;
        case (op_r)
          OP_ADD_HEAD: begin
            pv_we = 1'b1;
            pv_wa = aux_r[IDX_W-1:0];
            pv_wd = LINK_W'(new_r);
          end
          OP_ADD_TAIL: begin
            nx_we = 1'b1;
            nx_wa = aux_r[IDX_W-1:0];
            nx_wd = LINK_W'(new_r);
          end
          default: begin
            // add after: hook the new slot between position and successor
            nx_we = 1'b1;
            nx_wa = pos_idx;
            nx_wd = LINK_W'(new_r);
            if (aux_r >= NULL_LINK) begin
              tail_nxt = new_r;
            end else begin
              pv_we = 1'b1;
              pv_wa = aux_r[IDX_W-1:0];
              pv_wd = LINK_W'(new_r);
            end
          end
        endcase
      end

      S_EMIT: begin
        if (emit_go) begin
          if ((op_r == OP_READ_OUT) && !res_last_r) begin
            rd_en     = 1'b1;
            rd_addr   = aux_r[IDX_W-1:0];
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      free_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operation capture, working and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      pos_r  <= in_position;
      data_r <= DATA_WIDTH'(in_entry_data);
      new_r  <= lowest_free;
    end
    aux_r        <= aux_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_data_r   <= res_data_nxt;
    res_last_r   <= res_last_nxt;
    if (emit_go) begin
      out_status_r <= res_status_r;
      out_slot_r   <= SLOT_W'(res_slot_r);
      out_data_r   <= ENTRY_W'(res_data_r);
      out_last_r   <= res_last_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  // slot stores: one write port each, one shared registered read address
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (dat_we) data_mem[new_r] <= data_r;
    if (rd_en) begin
      next_rd_r <= next_mem[rd_addr];
      prev_rd_r <= prev_mem[rd_addr];
      data_rd_r <= data_mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_entry_data_out = out_data_r;
  assign out_last           = out_last_r;
  assign out_count          = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_matches_free: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(~free_r) == int'(count_r))
    else $error("entry count disagrees with free marks");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0) && (tail_r == '0))
    else $error("empty list with non-zero head or tail");

  a_ends_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> !free_r[head_r] && !free_r[tail_r])
    else $error("head or tail points at a free slot");

  a_single_beat_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && (op_r != OP_READ_OUT)) |-> res_last_r)
    else $error("non read-out operation gave more than one beat");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && res_last_r) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final beat");

endmodule
`default_nettype wire

// ===== dv/array_doubly_linked_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_tb
// Self-checking bench for the slot-store doubly linked list.
// ----------------------------------------------------------------------------
// A queue of operation beats, filled by the sequencing initial block, feeds a
// clocked driver. Every accepted operation is run through a behavioural copy
// of the list (own links, free marks, data words, head, tail and count) that
// queues the result beats it should cause. A clocked monitor pops and compares
// each result beat field by field. The run steps through several idling
// phases, one long receiver hold-off and a full drain at every phase change.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_tb;
  import adll_pkg::*;

  localparam int NSLOT = DEPTH_DEF;
  localparam logic [COUNT_W-1:0] NIL = COUNT_W'(NSLOT);  // null link
  // receiver hold-off long enough for the block to fill and stall its input
  localparam int HOLD_CYCLES = 300;
  // Slowest legal gap between any two accepted beats: a read out of 16
  // entries under random stalls, or the single hold-off above. Several
  // times that, with margin.
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int SHOW_MAX    = 10;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [ENTRY_W-1:0] data;
  } list_req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] data;
    logic               last;
    logic [COUNT_W-1:0] count;
  } list_beat_t;

  // flavour of a burst of random operations
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY, MIX_NOISE} burst_mix_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [ENTRY_W-1:0]  in_entry_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [ENTRY_W-1:0]  out_entry_data_out;
  logic                out_last;
  logic [COUNT_W-1:0]  out_count;

  // list copy
  logic [SLOT_W-1:0]   lst_head;
  logic [SLOT_W-1:0]   lst_tail;
  logic [COUNT_W-1:0]  lst_count;
  logic [COUNT_W-1:0]  lst_next [NSLOT];
  logic [COUNT_W-1:0]  lst_prev [NSLOT];
  logic                lst_free [NSLOT];
  logic [ENTRY_W-1:0]  lst_data [NSLOT];

  list_req_t  op_backlog [$];   // operations waiting for the driver
  list_beat_t beats_due [$];    // result beats still to arrive
  list_req_t  drv_req;
  list_beat_t want;

  int ops_queued    = 0;
  int ops_taken     = 0;
  int bad_beats     = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_go       = 1'b0;
  int hold_cnt      = 0;
  int quiet_cycles  = 0;

  array_doubly_linked_list i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_entry_data      (in_entry_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_entry_data_out (out_entry_data_out),
    .out_last           (out_last),
    .out_count          (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // List copy and its result prediction
  // --------------------------------------------------------------------------
  function automatic void clear_list();
    for (int i = 0; i < NSLOT; i++) begin
      lst_next[i] = NIL;
      lst_prev[i] = NIL;
      lst_free[i] = 1'b1;
    end
    lst_head  = '0;
    lst_tail  = '0;
    lst_count = '0;
  endfunction

  function automatic void queue_beat(status_t st, logic [SLOT_W-1:0] sl,
                                     logic [ENTRY_W-1:0] d, logic lst);
    list_beat_t b;
    b.status = st;
    b.slot   = sl;
    b.data   = d;
    b.last   = lst;
    b.count  = lst_count;
    beats_due.push_back(b);
  endfunction

  // lowest free slot gets the new entry
  function automatic logic [SLOT_W-1:0] take_slot(logic [ENTRY_W-1:0] d);
    logic [SLOT_W-1:0] s;
    bit                found;
    s     = '0;
    found = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!found && lst_free[i]) begin
        s     = SLOT_W'(i);
        found = 1'b1;
      end
    end
    lst_free[s] = 1'b0;
    lst_data[s] = d;
    lst_next[s] = NIL;
    lst_prev[s] = NIL;
    lst_count   = lst_count + 1'b1;
    return s;
  endfunction

  function automatic void release_slot(logic [SLOT_W-1:0] s);
    lst_free[s] = 1'b1;
    lst_next[s] = NIL;
    lst_prev[s] = NIL;
    lst_count   = lst_count - 1'b1;
  endfunction

  function automatic void apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                        logic [ENTRY_W-1:0] d);
    logic               pos_ok;
    logic [SLOT_W-1:0]  s;
    logic [COUNT_W-1:0] n;
    logic [SLOT_W-1:0]  cur;
    logic [COUNT_W-1:0] nx;
    logic               fin;
    bit                 done;
    int                 k;
    pos_ok = !lst_free[pos];
    case (op)
      OP_ADD_HEAD, OP_ADD_TAIL: begin
        if (lst_count >= NSLOT) begin
          queue_beat(ST_FULL, '0, '0, 1'b1);
        end else begin
          s = take_slot(d);
          if (lst_count == 1) begin
            lst_head = s;
            lst_tail = s;
          end else if (op == OP_ADD_HEAD) begin
            lst_next[s]        = COUNT_W'(lst_head);
            lst_prev[lst_head] = COUNT_W'(s);
            lst_head           = s;
          end else begin
            lst_prev[s]        = COUNT_W'(lst_tail);
            lst_next[lst_tail] = COUNT_W'(s);
            lst_tail           = s;
          end
          queue_beat(ST_OK, s, '0, 1'b1);
        end
      end
      OP_ADD_AFTER: begin
        // position check comes before the full check
        if (!pos_ok) begin
          queue_beat(ST_BAD_POS, '0, '0, 1'b1);
        end else if (lst_count >= NSLOT) begin
          queue_beat(ST_FULL, '0, '0, 1'b1);
        end else begin
          s             = take_slot(d);
          n             = lst_next[pos];
          lst_prev[s]   = COUNT_W'(pos);
          lst_next[s]   = n;
          lst_next[pos] = COUNT_W'(s);
          if (n == NIL) lst_tail = s;
          else lst_prev[n[SLOT_W-1:0]] = COUNT_W'(s);
          queue_beat(ST_OK, s, '0, 1'b1);
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (lst_count == 0) begin
          queue_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          if (lst_count == 1) begin
            s = lst_head;
            release_slot(s);
            lst_head = '0;
            lst_tail = '0;
          end else if (op == OP_DEL_HEAD) begin
            s                  = lst_head;
            lst_head           = lst_next[s][SLOT_W-1:0];
            lst_prev[lst_head] = NIL;
            release_slot(s);
          end else begin
            s                  = lst_tail;
            lst_tail           = lst_prev[s][SLOT_W-1:0];
            lst_next[lst_tail] = NIL;
            release_slot(s);
          end
          queue_beat(ST_OK, s, '0, 1'b1);
        end
      end
      OP_DEL_AFTER: begin
        if (!pos_ok) begin
          queue_beat(ST_BAD_POS, '0, '0, 1'b1);
        end else if (lst_next[pos] >= NSLOT) begin
          // position is the tail, nothing after it
          queue_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          s             = lst_next[pos][SLOT_W-1:0];
          n             = lst_next[s];
          lst_next[pos] = n;
          if (n == NIL) lst_tail = pos;
          else lst_prev[n[SLOT_W-1:0]] = COUNT_W'(pos);
          release_slot(s);
          queue_beat(ST_OK, s, '0, 1'b1);
        end
      end
      OP_READ_OUT: begin
        if (lst_count == 0) begin
          queue_beat(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // walk head to tail, one beat per entry
          cur  = lst_head;
          k    = 0;
          done = 1'b0;
          while (!done && k < MAX_RESULTS && k < lst_count) begin
            nx  = lst_next[cur];
            fin = (k + 1 == lst_count) || (k + 1 == MAX_RESULTS) || (nx >= NSLOT);
            queue_beat(ST_OK, cur, lst_data[cur], fin);
            k++;
            done = fin;
            cur  = nx[SLOT_W-1:0];
          end
        end
      end
      default: begin
        // clear keeps the data words, frees everything else
        clear_list();
        queue_beat(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one beat on offer at a time, held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_op(op_t'(in_operation), in_position, in_entry_data);
        ops_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_req = op_backlog.pop_front();
          in_valid      <= 1'b1;
          in_operation  <= drv_req.op;
          in_position   <= drv_req.pos;
          in_entry_data <= drv_req.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares each result beat with the oldest prediction and drives
  // the receiver stall (random, or the one long hold-off)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= SHOW_MAX)
            $display("unexpected result beat: st=%0d slot=%0d data=%h last=%0b cnt=%0d",
                     out_status, out_slot, out_entry_data_out, out_last, out_count);
        end else begin
          want = beats_due.pop_front();
          if (out_status !== want.status || out_slot !== want.slot ||
              out_entry_data_out !== want.data || out_last !== want.last ||
              out_count !== want.count) begin
            bad_beats++;
            if (bad_beats <= SHOW_MAX) begin
              $display("result mismatch: exp st=%0d slot=%0d data=%h last=%0b cnt=%0d",
                       want.status, want.slot, want.data, want.last, want.count);
              $display("                 got st=%0d slot=%0d data=%h last=%0b cnt=%0d",
                       out_status, out_slot, out_entry_data_out, out_last, out_count);
            end
          end
        end
      end
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_cnt++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog: too long without any beat accepted on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_req(op_t op, logic [POS_W-1:0] pos, logic [ENTRY_W-1:0] d);
    list_req_t r;
    r.op   = op;
    r.pos  = pos;
    r.data = d;
    op_backlog.push_back(r);
    ops_queued++;
  endtask

  // a slot that is linked right now, if any
  function automatic logic [POS_W-1:0] linked_pos();
    logic [POS_W-1:0] p;
    p = POS_W'($urandom_range(0, NSLOT - 1));
    if (lst_count != 0)
      for (int i = 0; i < NSLOT; i++)
        if (lst_free[p]) p = p + 1'b1;
    return p;
  endfunction

  function automatic op_t pick_op(int add_pct, int del_pct, int read_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) return op_t'($urandom_range(0, 2));
    else if (roll < add_pct + del_pct) return op_t'($urandom_range(3, 5));
    else if (roll < add_pct + del_pct + read_pct) return OP_READ_OUT;
    else return OP_CLEAR;
  endfunction

  // Bursts of well-formed operations (positions on linked slots) that grow,
  // shrink or churn the list, with the odd burst of pure noise. The list copy
  // lags the generator by a beat or two, so a few positions go stale.
  task automatic feed_random(int n);
    burst_mix_t       mix;
    int               burst_left;
    int               roll;
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [ENTRY_W-1:0] d;
    mix        = MIX_ANY;
    burst_left = 0;
    while (n > 0) begin
      @(negedge clk);
      if (op_backlog.size() < 2) begin
        if (burst_left == 0) begin
          roll       = $urandom_range(0, 99);
          mix        = roll < 35 ? MIX_GROW : roll < 65 ? MIX_SHRINK :
                       roll < 90 ? MIX_ANY : MIX_NOISE;
          burst_left = $urandom_range(4, 24);
        end
        case (mix)
          MIX_GROW:   op = pick_op(62, 22, 14);
          MIX_SHRINK: op = pick_op(20, 62, 16);
          MIX_ANY:    op = pick_op(42, 42, 14);
          default:    op = op_t'($urandom_range(0, 7));
        endcase
        if (mix == MIX_NOISE || $urandom_range(0, 9) == 0)
          pos = POS_W'($urandom_range(0, NSLOT - 1));
        else
          pos = linked_pos();
        roll = $urandom_range(0, 19);
        d    = roll == 0 ? '1 : roll == 1 ? '0 : {$urandom, $urandom};
        push_req(op, pos, d);
        n--;
        burst_left--;
      end
    end
  endtask

  // sender pauses until every operation is taken and every result is back
  task automatic drain_all();
    while (ops_taken != ops_queued) @(negedge clk);
    while (beats_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    clear_list();
    for (int i = 0; i < NSLOT; i++) lst_data[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase A, no idling: directed corner cases first
    push_req(OP_READ_OUT, '0, '0);                  // read out of an empty list
    push_req(OP_DEL_TAIL, '0, '0);                  // delete from an empty list
    push_req(OP_DEL_AFTER, 4'hF, '0);               // position on a free slot
    push_req(OP_ADD_AFTER, 4'h0, {$urandom, $urandom});
    push_req(OP_ADD_HEAD, '0, '1);                  // all-ones record
    for (int i = 0; i < 14; i++)
      push_req(OP_ADD_TAIL, POS_W'(i), i == 6 ? '0 : {$urandom, $urandom});
    push_req(OP_ADD_AFTER, 4'h0, {$urandom, $urandom});  // fills the last slot
    push_req(OP_ADD_HEAD, '0, {$urandom, $urandom});     // refused, full
    push_req(OP_ADD_AFTER, 4'h3, {$urandom, $urandom});  // linked slot, but full
    push_req(OP_READ_OUT, '0, '0);                  // sixteen beats
    push_req(OP_DEL_AFTER, 4'hE, '0);               // tail: nothing after it
    push_req(OP_DEL_AFTER, 4'h0, '0);
    push_req(OP_DEL_HEAD, '0, '0);
    push_req(OP_DEL_TAIL, '0, '0);
    push_req(OP_CLEAR, '0, '0);
    push_req(OP_READ_OUT, '0, '0);
    feed_random(110);
    drain_all();

    // phase B: sender idles
    send_idle_pct = 55;
    feed_random(115);
    drain_all();

    // phase C: receiver stalls, opening with the long hold-off while the
    // sender keeps offering
    send_idle_pct = 0;
    stall_pct     = 55;
    hold_go       = 1'b1;
    feed_random(115);
    drain_all();

    // phase D: light idling on both sides
    send_idle_pct = 14;
    stall_pct     = 14;
    feed_random(110);
    drain_all();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (bad_beats == 0 && beats_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/adll_pkg.sv
design/array_doubly_linked_list.sv
dv/array_doubly_linked_list_tb.sv
